/* rtl/sfir_pkg.sv */
// sfir_pkg: shared types, constants and arithmetic helpers of the six channel decimating fir
// no dependencies
package sfir_pkg;

  localparam int TAP_COUNT_DEF  = 16;
  localparam int DECIMATION_DEF = 1;

  localparam int CH     = 6;
  localparam int SMP_W  = 16;
  localparam int TAP_W  = 16;
  localparam int PROD_W = SMP_W + TAP_W;
  localparam int ACC_W  = 40;
  localparam int POS_W  = 7;   // tap position width, covers the largest tap count
  localparam int TAB_N  = 16;  // designed tap set length

  typedef logic signed [SMP_W-1:0]  smp_t;
  typedef logic signed [TAP_W-1:0]  tap_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [ACC_W-1:0]  acc_t;
  typedef smp_t [CH-1:0]            smp_vec_t;
  typedef acc_t [CH-1:0]            acc_row_t;

  localparam tap_t TAP_TAB [TAB_N] = '{
    -16'sd91,   -16'sd203,  -16'sd163,  16'sd343,
    16'sd1545,  16'sd3341,  16'sd5206,  16'sd6406,
    16'sd6406,  16'sd5206,  16'sd3341,  16'sd1545,
    16'sd343,   -16'sd163,  -16'sd203,  -16'sd91
  };

  // q1.15 tap at a position, zero beyond the designed set
  function automatic tap_t tap_at(input logic [POS_W-1:0] pos);
    tap_t t;
    t = '0;
    if (pos < POS_W'(TAB_N)) begin
      t = TAP_TAB[pos[3:0]];
    end
    return t;
  endfunction

  // round half up back to sample scale, then saturate
  function automatic smp_t round_sat(input acc_t a);
    logic signed [ACC_W:0]       b;
    logic signed [ACC_W-15:0]    q;
    smp_t                        r;
    b = {a[ACC_W-1], a} + (ACC_W+1)'(16384);
    q = b[ACC_W:15];
    if (q > (ACC_W-14)'(32767)) begin
      r = 16'sh7fff;
    end else if (q < -(ACC_W-14)'(32768)) begin
      r = 16'sh8000;
    end else begin
      r = q[SMP_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/sfir_if.sv */
// sfir_in_if and sfir_out_if: valid/ready channels carrying six samples per item
// depends on sfir_pkg
interface sfir_in_if;
  logic             valid;
  logic             ready;
  sfir_pkg::smp_t   accel_x_in;
  sfir_pkg::smp_t   accel_y_in;
  sfir_pkg::smp_t   accel_z_in;
  sfir_pkg::smp_t   rate_x_in;
  sfir_pkg::smp_t   rate_y_in;
  sfir_pkg::smp_t   rate_z_in;

  modport source (output valid, accel_x_in, accel_y_in, accel_z_in,
                  rate_x_in, rate_y_in, rate_z_in, input ready);
  modport sink   (input valid, accel_x_in, accel_y_in, accel_z_in,
                  rate_x_in, rate_y_in, rate_z_in, output ready);
endinterface

interface sfir_out_if;
  logic             valid;
  logic             ready;
  sfir_pkg::smp_t   accel_x_out;
  sfir_pkg::smp_t   accel_y_out;
  sfir_pkg::smp_t   accel_z_out;
  sfir_pkg::smp_t   rate_x_out;
  sfir_pkg::smp_t   rate_y_out;
  sfir_pkg::smp_t   rate_z_out;

  modport source (output valid, accel_x_out, accel_y_out, accel_z_out,
                  rate_x_out, rate_y_out, rate_z_out, input ready);
  modport sink   (input valid, accel_x_out, accel_y_out, accel_z_out,
                  rate_x_out, rate_y_out, rate_z_out, output ready);
endinterface

/* rtl/sfir_front.sv */
// sfir_front: accepts items, tags each with its position in the tap cycle, two entry queue
// depends on sfir_pkg and sfir_in_if
module sfir_front #(
  parameter int TAP_COUNT = sfir_pkg::TAP_COUNT_DEF,
  localparam int IDX_W    = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  sfir_in_if.sink              in_if,
  output logic                 q_valid,
  output sfir_pkg::smp_vec_t   q_smp,
  output logic [IDX_W-1:0]     q_tag,
  input  logic                 q_pop
);

  sfir_pkg::smp_vec_t  ent_smp_r [2];
  logic [IDX_W-1:0]    ent_tag_r [2];
  logic                wr_ptr_r, rd_ptr_r;
  logic [1:0]          fill_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                push, pop;

  assign in_if.ready = (fill_r != 2'd2);
  assign push        = in_if.valid && in_if.ready;
  assign pop         = q_pop && q_valid;

  assign q_valid = (fill_r != 2'd0);
  assign q_smp   = ent_smp_r[rd_ptr_r];
  assign q_tag   = ent_tag_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
        cnt_r    <= (cnt_r == IDX_W'(TAP_COUNT - 1)) ? '0 : cnt_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      fill_r <= fill_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_smp_r[wr_ptr_r] <= {in_if.rate_z_in, in_if.rate_y_in, in_if.rate_x_in,
                              in_if.accel_z_in, in_if.accel_y_in, in_if.accel_x_in};
      ent_tag_r[wr_ptr_r] <= cnt_r;
    end
  end

endmodule

/* rtl/sfir_mac.sv */
// sfir_mac: walks the phases one per cycle, multiply-accumulate into the partial sum memory,
// emits and clears the phase whose tap index wraps; depends on sfir_pkg and sfir_out_if
module sfir_mac #(
  parameter int TAP_COUNT  = sfir_pkg::TAP_COUNT_DEF,
  parameter int DECIMATION = sfir_pkg::DECIMATION_DEF,
  localparam int IDX_W     = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  sfir_pkg::smp_vec_t   q_smp,
  input  logic [IDX_W-1:0]     q_tag,
  output logic                 q_pop,
  sfir_out_if.source           out_if
);

  localparam int NP   = TAP_COUNT / DECIMATION;
  localparam int PH_W = (NP > 1) ? $clog2(NP) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]              st_r, st_nxt;
  sfir_pkg::smp_vec_t      smp_r;
  logic [PH_W-1:0]         ph_r;
  logic [IDX_W-1:0]        idx_r;
  logic [IDX_W:0]          idx_sum;
  logic                    issue, last_ph;

  sfir_pkg::acc_row_t      mem [NP];
  sfir_pkg::acc_row_t      rdata_r;
  logic [NP-1:0]           vld_r;

  // stage 1
  logic                    v1_r, wrap1_r, rv1_r;
  logic [PH_W-1:0]         ph1_r;
  sfir_pkg::tap_t          tap1_r;
  // stage 2
  logic                    v2_r, wrap2_r;
  logic [PH_W-1:0]         ph2_r;
  sfir_pkg::prod_t         prod2_r [sfir_pkg::CH];
  sfir_pkg::acc_row_t      acc2_r;
  sfir_pkg::acc_row_t      sum2;
  // stage 3
  logic                    emit3_r;
  sfir_pkg::acc_row_t      sum3_r;
  // output register
  logic                    ov_r;
  sfir_pkg::smp_vec_t      od_r;

  assign issue   = (st_r == ST_RUN);
  assign last_ph = (ph_r == PH_W'(NP - 1));
  assign q_pop   = (st_r == ST_IDLE) && !ov_r;
  assign idx_sum = {1'b0, idx_r} + (IDX_W+1)'(DECIMATION);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:  if (q_valid && !ov_r) st_nxt = ST_RUN;
      ST_RUN:   if (last_ph) st_nxt = ST_DRAIN;
      ST_DRAIN: if (!v1_r && !v2_r && !emit3_r) st_nxt = ST_IDLE;
      default:  st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= ST_IDLE;
      ph_r    <= '0;
      vld_r   <= '0;
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      emit3_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (issue) begin
        ph_r <= last_ph ? '0 : ph_r + 1'b1;
      end
      v1_r    <= issue;
      v2_r    <= v1_r;
      emit3_r <= v2_r && wrap2_r;
      if (v2_r) begin
        vld_r[ph2_r] <= 1'b1;
      end
      if (emit3_r) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // item registers, index walk and pipeline payload
  always_ff @(posedge clk) begin
    if (q_pop && q_valid) begin
      smp_r <= q_smp;
      idx_r <= q_tag;
    end else if (issue) begin
      idx_r <= (idx_sum >= (IDX_W+1)'(TAP_COUNT)) ?
               IDX_W'(idx_sum - (IDX_W+1)'(TAP_COUNT)) : idx_sum[IDX_W-1:0];
    end
    if (issue) begin
      rdata_r <= mem[ph_r];
      rv1_r   <= vld_r[ph_r];
      ph1_r   <= ph_r;
      tap1_r  <= sfir_pkg::tap_at(sfir_pkg::POS_W'(idx_r));
      wrap1_r <= (idx_r == IDX_W'(TAP_COUNT - 1));
    end
    ph2_r   <= ph1_r;
    wrap2_r <= wrap1_r;
    acc2_r  <= rv1_r ? rdata_r : '0;
    for (int c = 0; c < sfir_pkg::CH; c++) begin
      prod2_r[c] <= smp_r[c] * tap1_r;
    end
    if (v2_r) begin
      mem[ph2_r] <= wrap2_r ? '0 : sum2;
    end
    sum3_r <= sum2;
    if (emit3_r) begin
      for (int c = 0; c < sfir_pkg::CH; c++) begin
        od_r[c] <= sfir_pkg::round_sat(sum3_r[c]);
      end
    end
  end

  always_comb begin
    for (int c = 0; c < sfir_pkg::CH; c++) begin
      sum2[c] = acc2_r[c] + {{(sfir_pkg::ACC_W - sfir_pkg::PROD_W){prod2_r[c][sfir_pkg::PROD_W-1]}},
                             prod2_r[c]};
    end
  end

  assign out_if.valid       = ov_r;
  assign out_if.accel_x_out = od_r[0];
  assign out_if.accel_y_out = od_r[1];
  assign out_if.accel_z_out = od_r[2];
  assign out_if.rate_x_out  = od_r[3];
  assign out_if.rate_y_out  = od_r[4];
  assign out_if.rate_z_out  = od_r[5];

endmodule

/* rtl/six_channel_decimating_fir.sv */
// six_channel_decimating_fir: top level, front queue plus phase multiply-accumulate engine
// depends on sfir_pkg, sfir_in_if, sfir_out_if, sfir_front, sfir_mac
//
//   channel   dir  handshake      payload
//   in_if     in   valid/ready    accel_x/y/z_in, rate_x/y/z_in, signed 16 bit each
//   out_if    out  valid/ready    accel_x/y/z_out, rate_x/y/z_out, signed 16 bit each
//
// for each item the engine pops it, walks one phase per cycle through the partial sum memory
// (read and written in the same cycle), then a three stage drain (mac, write back, round),
// plus any wait on the output register
// the front queue holds two items, so input is taken while the engine works or the
// result waits; the engine starts a new item only once the output register is free
// reset is synchronous, active low; the partial sums read as zero until first written
module six_channel_decimating_fir #(
  parameter int TAP_COUNT  = sfir_pkg::TAP_COUNT_DEF,
  parameter int DECIMATION = sfir_pkg::DECIMATION_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  sfir_in_if.sink     in_if,
  sfir_out_if.source  out_if
);

  localparam int IDX_W = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;

  // queue head between front and engine; tag is the item's place in the tap cycle
  logic                q_valid;
  logic                q_pop;
  sfir_pkg::smp_vec_t  q_smp;
  logic [IDX_W-1:0]    q_tag;

  // front: accept, tag, buffer
  sfir_front #(
    .TAP_COUNT (TAP_COUNT)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .q_valid (q_valid),
    .q_smp   (q_smp),
    .q_tag   (q_tag),
    .q_pop   (q_pop)
  );

  // back: per phase tap index is (phase * decimation + tag) mod taps, walked by adding
  // the decimation factor each cycle; the phase hitting the last tap emits and clears
  sfir_mac #(
    .TAP_COUNT  (TAP_COUNT),
    .DECIMATION (DECIMATION)
  ) u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_smp   (q_smp),
    .q_tag   (q_tag),
    .q_pop   (q_pop),
    .out_if  (out_if)
  );

endmodule
